// ----- rtl/ffba_pkg.sv -----
`timescale 1ns / 1ps

package ffba_pkg;

    localparam int DEF_MAX_BLOCKS = 32;
    localparam int HEADER_BYTES   = 40;
    localparam int MIN_ALLOC      = 32;

    localparam logic [29:0] SIZE_LIM   = 30'((1 << 30) - 1 - HEADER_BYTES);
    localparam logic [30:0] RESET_HEAP = 31'd65496;

    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_FREE    = 2'd1;
    localparam logic [1:0] CMD_REALLOC = 2'd2;

    typedef enum logic [2:0] {
        ST_OK, ST_NOSPACE, ST_ZERO, ST_DOUBLE, ST_BADADDR, ST_FREED
    } status_t;

    typedef enum logic [2:0] {
        OP_HOLD, OP_INIT, OP_EVAL_FIT, OP_EVAL_MATCH, OP_SPLIT, OP_TAKE, OP_MARK, OP_MERGE
    } cell_op_t;

    typedef enum logic [1:0] {
        JOB_ALLOC, JOB_FREE, JOB_RCHK
    } job_t;

    typedef enum logic [2:0] {
        S_IDLE, S_EVAL, S_SCAN, S_READ, S_DECIDE, S_MERGE_N, S_MERGE_P, S_DONE
    } state_t;

    typedef struct packed {
        logic [29:0] start;
        logic [29:0] size;
        logic        free;
    } entry_t;

    function automatic logic [29:0] clamp_heap(input logic [30:0] v);
        clamp_heap = (v > {1'b0, SIZE_LIM}) ? SIZE_LIM : v[29:0];
    endfunction

endpackage

// ----- rtl/ffba_cell.sv -----
`timescale 1ns / 1ps

module ffba_cell import ffba_pkg::*; #(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
    parameter int K          = 0,
    localparam int IDXW      = $clog2(MAX_BLOCKS),
    localparam int CNTW      = $clog2(MAX_BLOCKS + 1)
) (
    input  logic            aclk,
    input  cell_op_t        op,
    input  logic [IDXW-1:0] sel_idx,
    input  logic [CNTW-1:0] count,
    input  logic [30:0]     need,
    input  logic [29:0]     ptr,
    input  logic [29:0]     init_size,
    input  entry_t          left,
    input  entry_t          right,
    output entry_t          q,
    output logic            hit
);

    entry_t entry_reg, entry_next;
    logic   hit_reg, hit_next;
    logic   is_sel, is_next, is_after, in_use;

    always_comb begin
        is_sel   = ({1'b0, sel_idx} == (IDXW+1)'(K));
        is_next  = (({1'b0, sel_idx} + (IDXW+1)'(1)) == (IDXW+1)'(K));
        is_after = ((IDXW+1)'(K) > {1'b0, sel_idx});
        in_use   = (CNTW'(K) < count);
        entry_next = entry_reg;
        hit_next   = hit_reg;
        case (op)
            OP_INIT: begin
                if (K == 0) begin
                    entry_next.start = '0;
                    entry_next.size  = init_size;
                    entry_next.free  = 1'b1;
                end
                hit_next = 1'b0;
            end
            OP_EVAL_FIT: begin
                hit_next = in_use && entry_reg.free && ({1'b0, entry_reg.size} >= need);
            end
            OP_EVAL_MATCH: begin
                hit_next = in_use &&
                    (({1'b0, entry_reg.start} + 31'(HEADER_BYTES)) == {1'b0, ptr});
            end
            OP_SPLIT: begin
                if (is_sel) begin
                    entry_next.size = need[29:0];
                    entry_next.free = 1'b0;
                end else if (is_next) begin
                    entry_next.start = left.start + 30'(HEADER_BYTES) + need[29:0];
                    entry_next.size  = left.size - need[29:0] - 30'(HEADER_BYTES);
                    entry_next.free  = 1'b1;
                end else if (is_after) begin
                    entry_next = left;
                end
            end
            OP_TAKE: begin
                if (is_sel) entry_next.free = 1'b0;
            end
            OP_MARK: begin
                if (is_sel) entry_next.free = 1'b1;
            end
            OP_MERGE: begin
                if (is_sel) begin
                    entry_next.size = entry_reg.size + 30'(HEADER_BYTES) + right.size;
                end else if (is_after) begin
                    entry_next = right;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        hit_reg   <= hit_next;
    end

    assign q   = entry_reg;
    assign hit = hit_reg;

endmodule

// ----- rtl/first_fit_block_allocator.sv -----
`timescale 1ns / 1ps
// channel | ports                                                  | dir
// input   | s_valid s_ready s_cmd s_request_size s_pointer_offset   | in
//         | s_pointer_valid                                        |
// result  | m_valid m_ready m_status m_result_offset m_copy_bytes  | out
// config  | cfg_wr_en cfg_wr_data (heap_bytes)                     | in
// One item at a time, one table entry per search cycle.
// A moving reallocate walks the table three times.
// Reset and a heap_bytes write rebuild the table; s_ready is low in reset.
// A new item is taken while a finished result waits in the output register;
// its own result then holds until m_ready frees that register.

module first_fit_block_allocator import ffba_pkg::*; #(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [30:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [29:0] s_request_size,
    input  logic [29:0] s_pointer_offset,
    input  logic        s_pointer_valid,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [29:0] m_result_offset,
    output logic [29:0] m_copy_bytes
);

    localparam int IDXW = $clog2(MAX_BLOCKS);
    localparam int CNTW = $clog2(MAX_BLOCKS + 1);

    state_t          state_reg, state_next;
    job_t            job_reg, job_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic [CNTW-1:0] idx_reg, idx_next;
    logic [29:0]     req_reg, req_next;
    logic [29:0]     ptr_reg, ptr_next;
    logic [30:0]     need_reg, need_next;
    logic            moving_reg, moving_next;
    status_t         st_reg, st_next;
    logic [29:0]     res_reg, res_next;
    logic [29:0]     copy_reg, copy_next;
    entry_t          sel_reg, sel_next;
    logic            m_valid_reg, m_valid_next;
    logic [2:0]      m_status_reg, m_status_next;
    logic [29:0]     m_res_reg, m_res_next;
    logic [29:0]     m_copy_reg, m_copy_next;

    cell_op_t        cell_op;
    logic [IDXW-1:0] cell_idx;
    logic [29:0]     init_size;
    entry_t          q [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] hit_vec, free_vec;
    logic [30:0]     need_calc;
    logic [31:0]     split_lim;
    logic [CNTW-1:0] nxt_idx, prv_idx;

    genvar g;
    generate
        for (g = 0; g < MAX_BLOCKS; g++) begin : g_cell
            entry_t lft, rgt;
            if (g == 0) begin : g_first
                assign lft = '0;
            end else begin : g_mid
                assign lft = q[g-1];
            end
            if (g == MAX_BLOCKS - 1) begin : g_last
                assign rgt = '0;
            end else begin : g_body
                assign rgt = q[g+1];
            end
            ffba_cell #(.MAX_BLOCKS(MAX_BLOCKS), .K(g)) u_cell (
                .aclk      (aclk),
                .op        (cell_op),
                .sel_idx   (cell_idx),
                .count     (count_reg),
                .need      (need_reg),
                .ptr       (ptr_reg),
                .init_size (init_size),
                .left      (lft),
                .right     (rgt),
                .q         (q[g]),
                .hit       (hit_vec[g])
            );
            assign free_vec[g] = q[g].free;
        end
    endgenerate

    always_comb begin
        need_calc = (31'(s_request_size) + 31'd7) & ~31'd7;
        if (need_calc < 31'(MIN_ALLOC)) need_calc = 31'(MIN_ALLOC);
        split_lim = 32'(need_reg) + 32'(HEADER_BYTES) + 32'(MIN_ALLOC);
        nxt_idx   = idx_reg + CNTW'(1);
        prv_idx   = idx_reg - CNTW'(1);
        init_size = aresetn ? clamp_heap(cfg_wr_data) : clamp_heap(RESET_HEAP);
    end

    always_comb begin
        sel_next = '0;
        for (int k = 0; k < MAX_BLOCKS; k++) begin
            if (idx_reg[IDXW-1:0] == IDXW'(k)) sel_next = sel_next | q[k];
        end
    end

    always_comb begin
        state_next    = state_reg;
        job_next      = job_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        req_next      = req_reg;
        ptr_next      = ptr_reg;
        need_next     = need_reg;
        moving_next   = moving_reg;
        st_next       = st_reg;
        res_next      = res_reg;
        copy_next     = copy_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_res_next    = m_res_reg;
        m_copy_next   = m_copy_reg;
        cell_op       = OP_HOLD;
        cell_idx      = idx_reg[IDXW-1:0];
        s_ready       = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                s_ready = aresetn;
                if (s_valid) begin
                    req_next    = s_request_size;
                    ptr_next    = s_pointer_offset;
                    need_next   = need_calc;
                    moving_next = 1'b0;
                    st_next     = ST_OK;
                    res_next    = '0;
                    copy_next   = '0;
                    state_next  = S_DONE;
                    if (s_cmd == CMD_ALLOC || (s_cmd == CMD_REALLOC && !s_pointer_valid)) begin
                        if (s_request_size == '0) begin
                            st_next = ST_ZERO;
                        end else begin
                            job_next   = JOB_ALLOC;
                            state_next = S_EVAL;
                        end
                    end else if (s_cmd == CMD_FREE) begin
                        if (s_pointer_valid) begin
                            job_next   = JOB_FREE;
                            state_next = S_EVAL;
                        end
                    end else if (s_cmd == CMD_REALLOC) begin
                        job_next   = (s_request_size == '0) ? JOB_FREE : JOB_RCHK;
                        state_next = S_EVAL;
                    end
                end
            end
            S_EVAL: begin
                cell_op    = (job_reg == JOB_ALLOC) ? OP_EVAL_FIT : OP_EVAL_MATCH;
                idx_next   = '0;
                state_next = S_SCAN;
            end
            S_SCAN: begin
                if (idx_reg == count_reg) begin
                    st_next    = (job_reg == JOB_ALLOC) ? ST_NOSPACE : ST_BADADDR;
                    res_next   = '0;
                    copy_next  = '0;
                    state_next = S_DONE;
                end else if (hit_vec[idx_reg[IDXW-1:0]]) begin
                    state_next = S_READ;
                end else begin
                    idx_next = idx_reg + CNTW'(1);
                end
            end
            S_READ: begin
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                unique case (job_reg)
                    JOB_ALLOC: begin
                        if ({2'b0, sel_reg.size} >= split_lim &&
                            count_reg < CNTW'(MAX_BLOCKS)) begin
                            cell_op    = OP_SPLIT;
                            count_next = count_reg + CNTW'(1);
                        end else begin
                            cell_op = OP_TAKE;
                        end
                        res_next = sel_reg.start + 30'(HEADER_BYTES);
                        if (moving_reg) begin
                            job_next   = JOB_FREE;
                            state_next = S_EVAL;
                        end else begin
                            state_next = S_DONE;
                        end
                    end
                    JOB_FREE: begin
                        if (sel_reg.free) begin
                            st_next    = ST_DOUBLE;
                            state_next = S_DONE;
                        end else begin
                            cell_op    = OP_MARK;
                            state_next = S_MERGE_N;
                        end
                    end
                    default: begin
                        if (sel_reg.free) begin
                            st_next    = ST_DOUBLE;
                            state_next = S_DONE;
                        end else if (sel_reg.size >= req_reg) begin
                            res_next   = ptr_reg;
                            state_next = S_DONE;
                        end else begin
                            copy_next   = sel_reg.size;
                            moving_next = 1'b1;
                            job_next    = JOB_ALLOC;
                            state_next  = S_EVAL;
                        end
                    end
                endcase
            end
            S_MERGE_N: begin
                if (nxt_idx < count_reg && free_vec[nxt_idx[IDXW-1:0]]) begin
                    cell_op    = OP_MERGE;
                    count_next = count_reg - CNTW'(1);
                end
                state_next = S_MERGE_P;
            end
            S_MERGE_P: begin
                cell_idx = prv_idx[IDXW-1:0];
                if (idx_reg != '0 && free_vec[prv_idx[IDXW-1:0]]) begin
                    cell_op    = OP_MERGE;
                    count_next = count_reg - CNTW'(1);
                end
                st_next    = moving_reg ? ST_OK : ST_FREED;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = st_reg;
                    m_res_next    = res_reg;
                    m_copy_next   = copy_reg;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (!aresetn || cfg_wr_en) begin
            cell_op    = OP_INIT;
            count_next = CNTW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= CNTW'(1);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        job_reg      <= job_next;
        idx_reg      <= idx_next;
        req_reg      <= req_next;
        ptr_reg      <= ptr_next;
        need_reg     <= need_next;
        moving_reg   <= moving_next;
        st_reg       <= st_next;
        res_reg      <= res_next;
        copy_reg     <= copy_next;
        sel_reg      <= sel_next;
        m_status_reg <= m_status_next;
        m_res_reg    <= m_res_next;
        m_copy_reg   <= m_copy_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_result_offset = m_res_reg;
    assign m_copy_bytes    = m_copy_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != '0 && count_reg <= CNTW'(MAX_BLOCKS))
        else $error("block count out of range");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SCAN |-> idx_reg <= count_reg)
        else $error("scan index past table end");

    a_split_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cell_op == OP_SPLIT |-> count_reg < CNTW'(MAX_BLOCKS))
        else $error("split with full table");

    a_merge_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (cell_op == OP_MERGE && !cfg_wr_en) |=> count_reg == $past(count_reg) - CNTW'(1))
        else $error("merge did not drop one block");

endmodule
